### rtl/bgs_pkg.sv
// Shared types and constants for the bilinear grid sampler.
// Used by bgs_mac, bgs_div and the top level; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package bgs_pkg;

	// Field and datapath widths
	localparam int COORD_W  = 32;              // signed Q24.8 coordinates and bounds
	localparam int DIM_W    = 11;              // grid width and height registers
	localparam int VAL_W    = 16;              // Q1.15 densities
	localparam int FRAC_W   = 16;              // fraction of the scaled position
	localparam int POS_W    = DIM_W + FRAC_W;  // scaled position, cell and fraction
	localparam int Q_W      = 28;              // quotient bits, even for two bits a cycle
	localparam int REM_W    = 33;              // divisor and remainder width
	localparam int DIV_PRE  = Q_W - FRAC_W;    // product bits above the shifted-in part
	localparam int MUL_A_W  = 33;
	localparam int MUL_B_W  = 17;
	localparam int ACC_W    = MUL_A_W + MUL_B_W;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	// Operation codes
	localparam logic OP_WRITE  = 1'b0;
	localparam logic OP_SAMPLE = 1'b1;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_BOUNDS_MIN_X = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_BOUNDS_MIN_Y = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_BOUNDS_MAX_X = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_BOUNDS_MAX_Y = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_BOUNDS_VALID = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_FALLBACK     = 3'd7;

	// Numeric constants
	localparam logic [VAL_W-1:0]          ONE_Q15    = 16'h8000;
	localparam logic [MUL_B_W-1:0]        ONE_FRAC   = 17'h1_0000;
	localparam logic signed [REM_W-1:0]   MIN_EXTENT = 33'sd256;
	localparam logic [ACC_W-1:0]          ROUND_HALF = 50'h0_0000_8000_0000;

	// One operation for the shared multiply-accumulate unit
	typedef struct packed {
		logic               issue;
		logic               clear;
		logic [MUL_A_W-1:0] a;
		logic [MUL_B_W-1:0] b;
	} mac_op_t;

endpackage

`default_nettype wire

### rtl/bgs_grid_mem.sv
// Density grid store: one write port and one registered read port.
// Depends on nothing; the depth comes from the top-level parameter.
`timescale 1ns / 1ps
`default_nettype none

module bgs_grid_mem #(
	parameter int GRID_CELLS = 65536
) (
	input  wire                          clk,
	input  wire                          wr_en,
	input  wire [$clog2(GRID_CELLS)-1:0] wr_addr,
	input  wire [15:0]                   wr_data,
	input  wire                          rd_en,
	input  wire [$clog2(GRID_CELLS)-1:0] rd_addr,
	output logic [15:0]                  rd_data
);

	logic [15:0] mem [GRID_CELLS];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

### rtl/bgs_mac.sv
// Shared multiply-accumulate unit: a registered 33x17 product, then an accumulator.
// The registered product is then added into acc. Uses bgs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bgs_mac
	import bgs_pkg::*;
(
	input  wire               clk,
	input  wire               arst_n,
	input  mac_op_t           op,
	output logic [ACC_W-1:0]  acc
);

	logic             v_s1;
	logic             clr_s1;
	logic [ACC_W-1:0] prod_s1;
	logic [ACC_W-1:0] acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= op.issue;
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= ACC_W'(op.a) * ACC_W'(op.b);
		clr_s1  <= op.clear;
		if (v_s1) begin
			acc_q <= (clr_s1 ? '0 : acc_q) + prod_s1;
		end
	end

	assign acc = acc_q;

endmodule

`default_nettype wire

### rtl/bgs_div.sv
// Restoring divider that retires two quotient bits a cycle.
// The caller guarantees the initial remainder is below the divisor. Uses bgs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bgs_div
	import bgs_pkg::*;
(
	input  wire              clk,
	input  wire              arst_n,
	input  wire              start,
	input  wire [REM_W-1:0]  rem_init,
	input  wire [Q_W-1:0]    bits_in,
	input  wire [REM_W-1:0]  divisor,
	output logic             done,
	output logic [Q_W-1:0]   quotient
);

	localparam int STEPS = Q_W / 2;
	localparam int CNT_W = $clog2(STEPS + 1);

	logic [CNT_W-1:0] cnt_q;
	logic             done_q;
	logic [REM_W-1:0] rem_q;
	logic [REM_W-1:0] div_q;
	logic [Q_W-1:0]   shift_q;

	logic [REM_W:0]   r1;
	logic [REM_W:0]   r1s;
	logic [REM_W:0]   r2;
	logic [REM_W:0]   r2s;
	logic             q1;
	logic             q2;

	// The numerator bits shift out at the top while quotient bits enter at the bottom.
	always_comb begin
		r1  = {rem_q, shift_q[Q_W-1]};
		q1  = (r1 >= {1'b0, div_q});
		r1s = q1 ? (r1 - {1'b0, div_q}) : r1;
		r2  = {r1s[REM_W-1:0], shift_q[Q_W-2]};
		q2  = (r2 >= {1'b0, div_q});
		r2s = q2 ? (r2 - {1'b0, div_q}) : r2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= CNT_W'(STEPS);
			end else if (cnt_q != '0) begin
				cnt_q  <= cnt_q - CNT_W'(1);
				done_q <= (cnt_q == CNT_W'(1));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q   <= rem_init;
			shift_q <= bits_in;
			div_q   <= divisor;
		end else if (cnt_q != '0) begin
			rem_q   <= r2s[REM_W-1:0];
			shift_q <= {shift_q[Q_W-3:0], q1, q2};
		end
	end

	assign done     = done_q;
	assign quotient = shift_q;

endmodule

`default_nettype wire

### rtl/bilinear_grid_sampler.sv
// Bilinear grid sampler: a write gives no result. A sample runs an area check, then for
// each axis a clamp at a bound or a division in the shared divider, then the cell and row
// addressing and the blend on the single multiplier, and ends with its result strobe
// (done); a fallback result follows the area check. One sample is in work at a time.
// Reset is asynchronous and active low and loads the register defaults; the grid store
// is not cleared. The receiver cannot stall: done is high for exactly one cycle.
`timescale 1ns / 1ps
`default_nettype none

module bilinear_grid_sampler
	import bgs_pkg::*;
#(
	parameter int GRID_CELLS = 65536
) (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    start,
	output logic                   busy,
	input  wire                    operation,
	input  wire [15:0]             cell_index,
	input  wire [VAL_W-1:0]        cell_value,
	input  wire [COORD_W-1:0]      location_x,
	input  wire [COORD_W-1:0]      location_y,
	output logic                   done,
	output logic [VAL_W-1:0]       density,
	output logic                   used_fallback,
	input  wire                    cfg_wr_en,
	input  wire [CFG_IDX_W-1:0]    cfg_index,
	input  wire [CFG_DATA_W-1:0]   cfg_wdata
);

	localparam int IDX_W = $clog2(GRID_CELLS);
	localparam logic [3:0] BLEND_LAST = 4'd9;

	typedef enum logic [3:0] {
		S_IDLE, S_AREA, S_FCHK, S_PREP, S_CLAMP, S_MUL, S_DIVGO, S_DIV,
		S_CELL, S_ROWW, S_ROW, S_BLEND
	} state_t;

	// Configuration registers
	logic [DIM_W-1:0]          w_q;
	logic [DIM_W-1:0]          h_q;
	logic signed [COORD_W-1:0] min_x_q;
	logic signed [COORD_W-1:0] min_y_q;
	logic signed [COORD_W-1:0] max_x_q;
	logic signed [COORD_W-1:0] max_y_q;
	logic                      bvalid_q;
	logic [VAL_W-1:0]          fb_q;

	// Sequencer and datapath
	state_t              state_q;
	logic                axis_q;
	logic [3:0]          step_q;
	logic                done_q;
	logic [VAL_W-1:0]    density_q;
	logic                used_fb_q;

	logic [COORD_W-1:0]      loc_x_q;
	logic [COORD_W-1:0]      loc_y_q;
	logic signed [REM_W-1:0] off_q;
	logic signed [REM_W-1:0] ext_q;
	logic [POS_W-1:0]        pos_x_q;
	logic [POS_W-1:0]        pos_y_q;
	logic [DIM_W-1:0]        x0_q;
	logic [DIM_W-1:0]        x1_q;
	logic [DIM_W-1:0]        y0_q;
	logic [DIM_W-1:0]        y1_q;
	logic [FRAC_W-1:0]       tx_q;
	logic [FRAC_W-1:0]       ty_q;
	logic [IDX_W-1:0]        row0_q;
	logic [IDX_W-1:0]        row1_q;
	logic [MUL_A_W-1:0]      a_q;

	// Combinational helpers
	logic                    accept;
	logic                    fallback_c;
	logic [COORD_W-1:0]      loc_sel;
	logic [COORD_W-1:0]      lo_sel;
	logic [COORD_W-1:0]      hi_sel;
	logic [DIM_W-1:0]        span_c;
	logic signed [REM_W-1:0] off_c;
	logic signed [REM_W-1:0] ext_raw;
	logic signed [REM_W-1:0] ext_c;
	logic                    off_low;
	logic                    off_high;
	logic [DIM_W-1:0]        wm1;
	logic [DIM_W-1:0]        hm1;
	logic [DIM_W-1:0]        x0c;
	logic [DIM_W-1:0]        x1c;
	logic [DIM_W-1:0]        y0c;
	logic [DIM_W-1:0]        y1c;
	logic [MUL_B_W-1:0]      wx;
	logic [MUL_B_W-1:0]      wy;
	logic [ACC_W-1:0]        round_c;
	logic [ACC_W-33:0]       rr_c;
	logic [VAL_W-1:0]        blend_c;

	mac_op_t              mac_op;
	logic [ACC_W-1:0]     acc;
	logic                 div_start;
	logic                 div_done;
	logic [Q_W-1:0]       quotient;
	logic                 mem_wr_en;
	logic                 mem_rd_en;
	logic [IDX_W-1:0]     mem_rd_addr;
	logic [VAL_W-1:0]     rd_data;

	assign accept = start && !busy;

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_q      <= DIM_W'(256);
			h_q      <= DIM_W'(256);
			min_x_q  <= '0;
			min_y_q  <= '0;
			max_x_q  <= '0;
			max_y_q  <= '0;
			bvalid_q <= 1'b0;
			fb_q     <= ONE_Q15;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				CFG_GRID_WIDTH:   w_q      <= cfg_wdata[DIM_W-1:0];
				CFG_GRID_HEIGHT:  h_q      <= cfg_wdata[DIM_W-1:0];
				CFG_BOUNDS_MIN_X: min_x_q  <= cfg_wdata;
				CFG_BOUNDS_MIN_Y: min_y_q  <= cfg_wdata;
				CFG_BOUNDS_MAX_X: max_x_q  <= cfg_wdata;
				CFG_BOUNDS_MAX_Y: max_y_q  <= cfg_wdata;
				CFG_BOUNDS_VALID: bvalid_q <= cfg_wdata[0];
				CFG_FALLBACK:     fb_q     <= cfg_wdata[VAL_W-1:0];
			endcase
		end
	end

	// Per-axis normalisation inputs, fallback check, cell clamps and blend rounding
	always_comb begin
		loc_sel  = axis_q ? loc_y_q : loc_x_q;
		lo_sel   = axis_q ? min_y_q : min_x_q;
		hi_sel   = axis_q ? max_y_q : max_x_q;
		wm1      = w_q - DIM_W'(1);
		hm1      = h_q - DIM_W'(1);
		span_c   = axis_q ? hm1 : wm1;
		off_c    = {loc_sel[COORD_W-1], loc_sel} - {lo_sel[COORD_W-1], lo_sel};
		ext_raw  = {hi_sel[COORD_W-1], hi_sel} - {lo_sel[COORD_W-1], lo_sel};
		ext_c    = (ext_raw < MIN_EXTENT) ? MIN_EXTENT : ext_raw;
		off_low  = (off_q <= 33'sd0);
		off_high = (off_q >= ext_q);

		fallback_c = (w_q < DIM_W'(2)) || (h_q < DIM_W'(2)) || !bvalid_q
			|| (acc > ACC_W'(GRID_CELLS));

		x0c = (pos_x_q[POS_W-1:FRAC_W] > wm1) ? wm1 : pos_x_q[POS_W-1:FRAC_W];
		y0c = (pos_y_q[POS_W-1:FRAC_W] > hm1) ? hm1 : pos_y_q[POS_W-1:FRAC_W];
		x1c = (x0c == wm1) ? wm1 : x0c + DIM_W'(1);
		y1c = (y0c == hm1) ? hm1 : y0c + DIM_W'(1);

		wx = ONE_FRAC - MUL_B_W'(tx_q);
		wy = ONE_FRAC - MUL_B_W'(ty_q);

		round_c = acc + ROUND_HALF;
		rr_c    = round_c[ACC_W-1:32];
		blend_c = (rr_c > (ACC_W-32)'(ONE_Q15)) ? ONE_Q15 : rr_c[VAL_W-1:0];
	end

	// Operations for the shared multiplier and reads of the grid
	always_comb begin
		mac_op      = '0;
		mem_rd_en   = 1'b0;
		mem_rd_addr = row0_q + IDX_W'(x0_q);
		div_start   = (state_q == S_DIVGO);
		unique case (state_q)
			S_IDLE: begin
				if (accept && operation == OP_SAMPLE) begin
					mac_op = '{issue: 1'b1, clear: 1'b1, a: MUL_A_W'(w_q), b: MUL_B_W'(h_q)};
				end
			end
			S_CLAMP: begin
				if (!off_low && !off_high) begin
					mac_op = '{issue: 1'b1, clear: 1'b1, a: off_q, b: MUL_B_W'(span_c)};
				end
			end
			S_CELL: begin
				mac_op = '{issue: 1'b1, clear: 1'b1, a: MUL_A_W'(y0c), b: MUL_B_W'(w_q)};
			end
			S_BLEND: begin
				// Reads in order c00, c10, c01, c11; each cell reaches the
				// multiplier in the cycle after its read.
				unique case (step_q)
					4'd0: begin
						mem_rd_en   = 1'b1;
						mem_rd_addr = row0_q + IDX_W'(x0_q);
					end
					4'd1: begin
						mem_rd_en   = 1'b1;
						mem_rd_addr = row0_q + IDX_W'(x1_q);
						mac_op = '{issue: 1'b1, clear: 1'b1, a: MUL_A_W'(rd_data), b: wx};
					end
					4'd2: begin
						mem_rd_en   = 1'b1;
						mem_rd_addr = row1_q + IDX_W'(x0_q);
						mac_op = '{issue: 1'b1, clear: 1'b0, a: MUL_A_W'(rd_data),
							b: MUL_B_W'(tx_q)};
					end
					4'd3: begin
						mem_rd_en   = 1'b1;
						mem_rd_addr = row1_q + IDX_W'(x1_q);
						mac_op = '{issue: 1'b1, clear: 1'b1, a: MUL_A_W'(rd_data), b: wx};
					end
					4'd4: begin
						mac_op = '{issue: 1'b1, clear: 1'b0, a: MUL_A_W'(rd_data),
							b: MUL_B_W'(tx_q)};
					end
					4'd6: begin
						mac_op = '{issue: 1'b1, clear: 1'b1, a: a_q, b: wy};
					end
					4'd7: begin
						// The lower row blend is still in the accumulator this cycle.
						mac_op = '{issue: 1'b1, clear: 1'b0, a: acc[MUL_A_W-1:0],
							b: MUL_B_W'(ty_q)};
					end
					default: begin
						mac_op = '0;
					end
				endcase
			end
			default: begin
				mac_op = '0;
			end
		endcase
	end

	assign mem_wr_en = accept && operation == OP_WRITE
		&& (32'(cell_index) < 32'(GRID_CELLS));

	// Sequencer and registered outputs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			axis_q    <= 1'b0;
			step_q    <= '0;
			done_q    <= 1'b0;
			density_q <= '0;
			used_fb_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (accept && operation == OP_SAMPLE) begin
						state_q <= S_AREA;
					end
				end
				S_AREA: begin
					state_q <= S_FCHK;
				end
				S_FCHK: begin
					axis_q <= 1'b0;
					if (fallback_c) begin
						done_q    <= 1'b1;
						used_fb_q <= 1'b1;
						density_q <= (fb_q > ONE_Q15) ? ONE_Q15 : fb_q;
						state_q   <= S_IDLE;
					end else begin
						state_q <= S_PREP;
					end
				end
				S_PREP: begin
					state_q <= S_CLAMP;
				end
				S_CLAMP: begin
					if (off_low || off_high) begin
						axis_q  <= 1'b1;
						state_q <= axis_q ? S_CELL : S_PREP;
					end else begin
						state_q <= S_MUL;
					end
				end
				S_MUL: begin
					state_q <= S_DIVGO;
				end
				S_DIVGO: begin
					state_q <= S_DIV;
				end
				S_DIV: begin
					if (div_done) begin
						axis_q  <= 1'b1;
						state_q <= axis_q ? S_CELL : S_PREP;
					end
				end
				S_CELL: begin
					state_q <= S_ROWW;
				end
				S_ROWW: begin
					state_q <= S_ROW;
				end
				S_ROW: begin
					step_q  <= '0;
					state_q <= S_BLEND;
				end
				S_BLEND: begin
					step_q <= step_q + 4'd1;
					if (step_q == BLEND_LAST) begin
						done_q    <= 1'b1;
						used_fb_q <= 1'b0;
						density_q <= blend_c;
						state_q   <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		if (accept) begin
			loc_x_q <= location_x;
			loc_y_q <= location_y;
		end
		if (state_q == S_PREP) begin
			off_q <= off_c;
			ext_q <= ext_c;
		end
		if (state_q == S_CLAMP && (off_low || off_high)) begin
			if (axis_q) begin
				pos_y_q <= off_low ? '0 : {span_c, FRAC_W'(0)};
			end else begin
				pos_x_q <= off_low ? '0 : {span_c, FRAC_W'(0)};
			end
		end
		if (state_q == S_DIV && div_done) begin
			if (axis_q) begin
				pos_y_q <= quotient[POS_W-1:0];
			end else begin
				pos_x_q <= quotient[POS_W-1:0];
			end
		end
		if (state_q == S_CELL) begin
			x0_q <= x0c;
			x1_q <= x1c;
			y0_q <= y0c;
			y1_q <= y1c;
			tx_q <= pos_x_q[FRAC_W-1:0];
			ty_q <= pos_y_q[FRAC_W-1:0];
		end
		if (state_q == S_ROW) begin
			row0_q <= acc[IDX_W-1:0];
			row1_q <= acc[IDX_W-1:0] + ((y1_q != y0_q) ? IDX_W'(w_q) : '0);
		end
		if (state_q == S_BLEND && step_q == 4'd4) begin
			a_q <= acc[MUL_A_W-1:0];
		end
	end

	bgs_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.op     (mac_op),
		.acc    (acc)
	);

	bgs_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.rem_init (acc[DIV_PRE +: REM_W]),
		.bits_in  ({acc[DIV_PRE-1:0], FRAC_W'(0)}),
		.divisor  (ext_q),
		.done     (div_done),
		.quotient (quotient)
	);

	bgs_grid_mem #(
		.GRID_CELLS (GRID_CELLS)
	) u_mem (
		.clk     (clk),
		.wr_en   (mem_wr_en),
		.wr_addr (IDX_W'(cell_index)),
		.wr_data (cell_value),
		.rd_en   (mem_rd_en),
		.rd_addr (mem_rd_addr),
		.rd_data (rd_data)
	);

	assign busy          = (state_q != S_IDLE);
	assign done          = done_q;
	assign density       = density_q;
	assign used_fallback = used_fb_q;

	// A result transaction is never followed by another in the next cycle.
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe held for more than one cycle");

	// The block only leaves a sample by delivering its result.
	a_busy_fall_done: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done)
		else $error("sample finished without a result");

	// Every delivered density is saturated to one.
	a_density_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (density <= ONE_Q15))
		else $error("density above one");

	// The divider only finishes while the sequencer is waiting for it.
	a_div_owner: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == S_DIV))
		else $error("divider finished outside its wait state");

endmodule

`default_nettype wire
